### hw/rtl/rfidc_pkg.sv
// Shared constants, types and character mapping functions of the RFID frame checker.
package rfidc_pkg;

   localparam int TAG_CHARS_DEFAULT    = 10;
   localparam int TRAILER_SKIP_DEFAULT = 2;
   localparam int QUEUE_DEPTH          = 2;
   localparam int CSR_IDX_W            = 1;
   localparam int CSR_DATA_W           = 8;
   localparam int CHAR_W               = 8;
   localparam int INDEX_W              = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE   = 1'b1;

   localparam logic [CHAR_W-1:0] START_CODE_RESET = 8'd2;
   localparam logic [CHAR_W-1:0] END_CODE_RESET   = 8'd3;

   localparam logic [CHAR_W-1:0] DIGIT_LOW    = 8'd48;
   localparam logic [CHAR_W-1:0] DIGIT_HIGH   = 8'd57;
   localparam logic [CHAR_W-1:0] LETTER_SHIFT = 8'd55;
   localparam logic [CHAR_W-1:0] DIGIT_LIMIT  = 8'd10;

   typedef struct packed {
      logic full;
      logic empty;
   } rfidc_q_status_type;

   function automatic logic [CHAR_W-1:0] to_nibble(input logic [CHAR_W-1:0] c);
      if (c >= DIGIT_LOW && c <= DIGIT_HIGH) begin
         return c - DIGIT_LOW;
      end
      return c - LETTER_SHIFT;
   endfunction

   function automatic logic [CHAR_W-1:0] to_ascii(input logic [CHAR_W-1:0] v);
      if (v < DIGIT_LIMIT) begin
         return v + DIGIT_LOW;
      end
      return v + LETTER_SHIFT;
   endfunction

endpackage

### hw/rtl/rfidc_front.sv
// Frame parser: takes received bytes, stores the tag, checks end byte and checksum.
module rfidc_front #(
   parameter int TAG_CHARS    = rfidc_pkg::TAG_CHARS_DEFAULT,
   parameter int TRAILER_SKIP = rfidc_pkg::TRAILER_SKIP_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic [rfidc_pkg::CHAR_W-1:0]                  req_rx_byte,
   input  logic                                          csr_we,
   input  logic [rfidc_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [rfidc_pkg::CSR_DATA_W-1:0]              csr_wdata,
   input  rfidc_pkg::rfidc_q_status_type                 q_status,
   output logic                                          push,
   output logic [TAG_CHARS-1:0][rfidc_pkg::CHAR_W-1:0]   push_data
);
   import rfidc_pkg::*;

   localparam int CHECK_FIRST  = TAG_CHARS + 1;
   localparam int CHECK_SECOND = TAG_CHARS + 2;
   localparam int END_POS      = TAG_CHARS + TRAILER_SKIP + 3;
   localparam int PHASE_W      = $clog2(END_POS + 1);
   localparam int IDX_W        = $clog2(TAG_CHARS);

   logic [CHAR_W-1:0]                start_code_ff;
   logic [CHAR_W-1:0]                end_code_ff;
   logic [PHASE_W-1:0]               phase_ff, phase_in;
   logic [CHAR_W-1:0]                even_xor_ff, even_xor_in;
   logic [CHAR_W-1:0]                odd_xor_ff, odd_xor_in;
   logic [CHAR_W-1:0]                chk0_ff, chk0_in;
   logic [CHAR_W-1:0]                chk1_ff, chk1_in;
   logic [TAG_CHARS-1:0][CHAR_W-1:0] tag_store_ff;
   logic                             store_we;
   logic [IDX_W-1:0]                 tag_idx;
   logic                             accept;
   logic                             at_end;

   assign at_end    = (phase_ff == PHASE_W'(END_POS));
   assign req_ready = !(at_end && q_status.full);
   assign accept    = req_valid && req_ready;
   assign tag_idx   = IDX_W'(phase_ff - PHASE_W'(1));
   assign push_data = tag_store_ff;

   always_comb begin
      phase_in    = phase_ff;
      even_xor_in = even_xor_ff;
      odd_xor_in  = odd_xor_ff;
      chk0_in     = chk0_ff;
      chk1_in     = chk1_ff;
      store_we    = 1'b0;
      push        = 1'b0;
      if (accept) begin
         if (phase_ff == '0) begin
            if (req_rx_byte == start_code_ff) begin
               phase_in    = PHASE_W'(1);
               even_xor_in = '0;
               odd_xor_in  = '0;
            end
         end else if (phase_ff <= PHASE_W'(TAG_CHARS)) begin
            store_we = 1'b1;
            if (!tag_idx[0]) begin
               even_xor_in = even_xor_ff ^ to_nibble(req_rx_byte);
            end else begin
               odd_xor_in = odd_xor_ff ^ to_nibble(req_rx_byte);
            end
            phase_in = phase_ff + PHASE_W'(1);
         end else if (phase_ff == PHASE_W'(CHECK_FIRST)) begin
            chk0_in  = req_rx_byte;
            phase_in = phase_ff + PHASE_W'(1);
         end else if (phase_ff == PHASE_W'(CHECK_SECOND)) begin
            chk1_in  = req_rx_byte;
            phase_in = phase_ff + PHASE_W'(1);
         end else if (at_end) begin
            phase_in = '0;
            push     = (req_rx_byte == end_code_ff) &&
                       (to_ascii(even_xor_ff) == chk0_ff) &&
                       (to_ascii(odd_xor_ff) == chk1_ff);
         end else begin
            phase_in = phase_ff + PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
         phase_ff      <= '0;
         even_xor_ff   <= '0;
         odd_xor_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         even_xor_ff <= even_xor_in;
         odd_xor_ff  <= odd_xor_in;
         if (csr_we) begin
            case (csr_index)
               CSR_START_CODE: start_code_ff <= csr_wdata;
               CSR_END_CODE:   end_code_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      chk0_ff <= chk0_in;
      chk1_ff <= chk1_in;
      if (store_we) begin
         tag_store_ff[tag_idx] <= req_rx_byte;
      end
   end

endmodule

### hw/rtl/rfidc_queue.sv
// Two-entry queue of verified tags between the frame parser and the output stage.
module rfidc_queue #(
   parameter int TAG_CHARS = rfidc_pkg::TAG_CHARS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          push,
   input  logic [TAG_CHARS-1:0][rfidc_pkg::CHAR_W-1:0]   push_data,
   input  logic                                          pop,
   output logic [TAG_CHARS-1:0][rfidc_pkg::CHAR_W-1:0]   head_data,
   output rfidc_pkg::rfidc_q_status_type                 status
);
   import rfidc_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [TAG_CHARS-1:0][CHAR_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]               count_ff, count_in;

   assign head_data    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/rfidc_back.sv
// Output stage: walks the head tag of the queue and sends one character per beat.
module rfidc_back #(
   parameter int TAG_CHARS = rfidc_pkg::TAG_CHARS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  rfidc_pkg::rfidc_q_status_type                 q_status,
   input  logic [TAG_CHARS-1:0][rfidc_pkg::CHAR_W-1:0]   head_data,
   output logic                                          pop,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [rfidc_pkg::CHAR_W-1:0]                  rsp_tag_char,
   output logic [rfidc_pkg::INDEX_W-1:0]                 rsp_char_index,
   output logic                                          rsp_last_char
);
   import rfidc_pkg::*;

   localparam int IDX_W = $clog2(TAG_CHARS);

   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               last_ff, last_in;
   logic               load;
   logic               is_last;

   assign load    = !q_status.empty && (!valid_ff || rsp_ready);
   assign is_last = (cnt_ff == IDX_W'(TAG_CHARS - 1));
   assign pop     = load && is_last;

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      index_in = index_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = head_data[cnt_ff];
         index_in = INDEX_W'(cnt_ff);
         last_in  = is_last;
         cnt_in   = is_last ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_tag_char   = char_ff;
   assign rsp_char_index = index_ff;
   assign rsp_last_char  = last_ff;

endmodule

### hw/rtl/rfid_ascii_frame_checker.sv
// Top level of the RFID ASCII frame checker.
//
// The req channel takes one received serial byte per beat. A frame is the start
// code, TAG_CHARS tag characters, two checksum characters, TRAILER_SKIP ignored
// bytes and the end code. When the end byte matches and the XOR checksums of the
// even and odd tag nibbles match the checksum characters, the rsp channel sends
// the tag characters in order, one per beat, with their index and a last mark
// on the final one. Frames that fail are dropped without any beat.
// The parser takes one byte per cycle unless it stalls. A good tag is first written
// into the queue, then its characters pass through the output register, one per
// cycle while rsp_ready is high. A two-entry tag queue separates the parser from
// the output register, so the parser stalls only on an end byte while both
// entries are still occupied. The csr port writes start_code (index 0) or
// end_code (index 1). Reset clears the frame position, the queue and the output
// valid, and sets start_code to 2 and end_code to 3. A stalled rsp beat holds its payload.
module rfid_ascii_frame_checker #(
   parameter int TAG_CHARS    = rfidc_pkg::TAG_CHARS_DEFAULT,
   parameter int TRAILER_SKIP = rfidc_pkg::TRAILER_SKIP_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rfidc_pkg::CHAR_W-1:0]     req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rfidc_pkg::CHAR_W-1:0]     rsp_tag_char,
   output logic [rfidc_pkg::INDEX_W-1:0]    rsp_char_index,
   output logic                             rsp_last_char,
   input  logic                             csr_we,
   input  logic [rfidc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfidc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rfidc_pkg::*;

   rfidc_q_status_type               q_status;
   logic                             push;
   logic                             pop;
   logic [TAG_CHARS-1:0][CHAR_W-1:0] push_data;
   logic [TAG_CHARS-1:0][CHAR_W-1:0] head_data;

   rfidc_front #(
      .TAG_CHARS   (TAG_CHARS),
      .TRAILER_SKIP(TRAILER_SKIP)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   rfidc_queue #(
      .TAG_CHARS(TAG_CHARS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (q_status)
   );

   rfidc_back #(
      .TAG_CHARS(TAG_CHARS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tag_char  (rsp_tag_char),
      .rsp_char_index(rsp_char_index),
      .rsp_last_char (rsp_last_char)
   );

endmodule

### hw/rtl/rfidc_checker.sv
// Port-level assertions for the RFID frame checker and the bind that attaches them.
module rfidc_checker #(
   parameter int TAG_CHARS = rfidc_pkg::TAG_CHARS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rfidc_pkg::CHAR_W-1:0]  rsp_tag_char,
   input logic [rfidc_pkg::INDEX_W-1:0] rsp_char_index,
   input logic                          rsp_last_char
);
   import rfidc_pkg::*;

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(TAG_CHARS - 1);

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag_char) &&
                                  $stable(rsp_char_index) && $stable(rsp_last_char))
      else $error("stalled rsp beat changed");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_char == (rsp_char_index == LAST_INDEX)))
      else $error("last mark does not match the final index");

   a_tag_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_char |=>
         rsp_valid && (rsp_char_index == $past(rsp_char_index) + INDEX_W'(1)))
      else $error("tag characters not sent back to back in order");

endmodule

bind rfid_ascii_frame_checker rfidc_checker #(
   .TAG_CHARS(TAG_CHARS)
) u_rfidc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_tag_char  (rsp_tag_char),
   .rsp_char_index(rsp_char_index),
   .rsp_last_char (rsp_last_char)
);

### tb/tb_rfid_ascii_frame_checker.sv
// Self-checking testbench for the RFID ASCII frame checker: directed frame, random frames, stalls.
module tb_rfid_ascii_frame_checker;

   import rfidc_pkg::*;

   localparam int TAG_LEN      = 10;
   localparam int TRAILER_LEN  = 2;
   localparam int CHECK_POS_A  = TAG_LEN + 1;
   localparam int CHECK_POS_B  = TAG_LEN + 2;
   localparam int END_POS      = TAG_LEN + 2 + TRAILER_LEN + 1;
   localparam int DIR_ROWS     = 18;
   localparam int RAND_ITEMS   = 320;
   localparam int N_PHASES     = 5;
   localparam int HOLD_PHASE   = 2;
   localparam int SPLIT_PHASE  = 3;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT  = 2000;

   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'd57;
   localparam logic [CHAR_W-1:0] LETTER_BIAS   = 8'd55;
   localparam logic [CHAR_W-1:0] NIBBLE_DIGITS = 8'd10;

   typedef enum logic {ROW_QUIET, ROW_RELEASE} row_kind_e;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_END,
      FRAME_BAD_FIRST_SUM,
      FRAME_BAD_SECOND_SUM,
      FRAME_NOISE
   } frame_kind_e;

   typedef struct packed {
      logic [CHAR_W-1:0] rx;
      row_kind_e         kind;
   } dir_row_t;

   typedef struct packed {
      logic [CHAR_W-1:0]  tag_char;
      logic [INDEX_W-1:0] char_index;
      logic               last_char;
   } tag_beat_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHAR_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_W-1:0]     rsp_tag_char;
   logic [INDEX_W-1:0]    rsp_char_index;
   logic                  rsp_last_char;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rfid_ascii_frame_checker i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tag_char   (rsp_tag_char),
      .rsp_char_index (rsp_char_index),
      .rsp_last_char  (rsp_last_char),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Mirror of the frame parser.
   logic [CHAR_W-1:0] start_code_now = START_CODE_RESET;
   logic [CHAR_W-1:0] end_code_now   = END_CODE_RESET;
   int                frame_pos = 0;
   logic [CHAR_W-1:0] tag_buf [TAG_LEN];
   logic [CHAR_W-1:0] check_buf [2];
   logic [CHAR_W-1:0] even_acc = '0;
   logic [CHAR_W-1:0] odd_acc  = '0;

   tag_beat_t tag_chars_due [$];
   tag_beat_t head_beat;

   int  fail_count = 0;
   int  busy_items = 0;
   int  bytes_sent = 0;
   int  good_frames = 0;
   int  dropped_frames = 0;
   int  beats_seen = 0;
   int  quiet_cycles = 0;
   int  next_gap = 0;
   bit  req_burst = 1'b0;
   bit  rsp_burst = 1'b0;
   bit  hold_rsp = 1'b0;

   function automatic logic [CHAR_W-1:0] char_to_nibble(input logic [CHAR_W-1:0] c);
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         return c - ASCII_ZERO;
      end
      return c - LETTER_BIAS;
   endfunction

   function automatic logic [CHAR_W-1:0] nibble_to_char(input logic [CHAR_W-1:0] v);
      if (v < NIBBLE_DIGITS) begin
         return v + ASCII_ZERO;
      end
      return v + LETTER_BIAS;
   endfunction

   // Advances the parser mirror by one byte; returns 0 when the byte is ignored while idle.
   function automatic bit track_rx_byte(input logic [CHAR_W-1:0] b, input bit predict);
      tag_beat_t beat;
      if (frame_pos == 0) begin
         if (b == start_code_now) begin
            frame_pos = 1;
            even_acc = '0;
            odd_acc = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      if (frame_pos <= TAG_LEN) begin
         tag_buf[frame_pos-1] = b;
         if (((frame_pos - 1) % 2) == 0) begin
            even_acc ^= char_to_nibble(b);
         end else begin
            odd_acc ^= char_to_nibble(b);
         end
      end else if (frame_pos == CHECK_POS_A) begin
         check_buf[0] = b;
      end else if (frame_pos == CHECK_POS_B) begin
         check_buf[1] = b;
      end else if (frame_pos >= END_POS) begin
         frame_pos = 0;
         if (b == end_code_now && nibble_to_char(even_acc) == check_buf[0]
             && nibble_to_char(odd_acc) == check_buf[1]) begin
            good_frames++;
            for (int k = 0; k < TAG_LEN; k++) begin
               beat.tag_char = tag_buf[k];
               beat.char_index = INDEX_W'(k);
               beat.last_char = (k == TAG_LEN - 1);
               if (predict) begin
                  tag_chars_due.push_back(beat);
               end
            end
         end else begin
            dropped_frames++;
         end
         return 1'b1;
      end
      frame_pos++;
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [CHAR_W-1:0] b, input bit predict);
      if (next_gap > 0) begin
         repeat (next_gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (track_rx_byte(b, predict)) begin
         busy_items++;
      end
      bytes_sent++;
      next_gap = req_burst ? 0 : $urandom_range(0, 5);
      if (next_gap > 0) begin
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain_and_settle();
      if (next_gap == 0) begin
         req_valid <= 1'b0;
      end
      do @(posedge clock); while (tag_chars_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_codes(input logic [CHAR_W-1:0] s, input logic [CHAR_W-1:0] e);
      csr_we <= 1'b1;
      csr_index <= CSR_START_CODE;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_END_CODE;
      csr_wdata <= e;
      @(posedge clock);
      csr_we <= 1'b0;
      start_code_now = s;
      end_code_now = e;
   endtask

   task automatic send_frame();
      logic [CHAR_W-1:0] tag [TAG_LEN];
      logic [CHAR_W-1:0] ev;
      logic [CHAR_W-1:0] od;
      logic [CHAR_W-1:0] sum_a;
      logic [CHAR_W-1:0] sum_b;
      logic [CHAR_W-1:0] end_byte;
      frame_kind_e       kind;
      int                pick;
      pick = $urandom_range(0, 9);
      kind = (pick < 6) ? FRAME_GOOD : frame_kind_e'(pick - 5);
      req_burst = ($urandom_range(0, 3) == 0);
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      ev = '0;
      od = '0;
      for (int k = 0; k < TAG_LEN; k++) begin
         if ($urandom_range(0, 4) != 0) begin
            tag[k] = nibble_to_char(8'($urandom_range(0, 15)));
         end else begin
            tag[k] = 8'($urandom_range(0, 255));
         end
         if ((k % 2) == 0) begin
            ev ^= char_to_nibble(tag[k]);
         end else begin
            od ^= char_to_nibble(tag[k]);
         end
      end
      sum_a = nibble_to_char(ev);
      sum_b = nibble_to_char(od);
      if (kind == FRAME_BAD_FIRST_SUM) begin
         sum_a ^= 8'($urandom_range(1, 255));
      end
      if (kind == FRAME_BAD_SECOND_SUM) begin
         sum_b ^= 8'($urandom_range(1, 255));
      end
      end_byte = end_code_now;
      if (kind == FRAME_BAD_END) begin
         end_byte ^= 8'($urandom_range(1, 255));
      end
      send_byte(start_code_now, 1'b1);
      for (int k = 0; k < TAG_LEN; k++) begin
         send_byte(tag[k], 1'b1);
      end
      send_byte(sum_a, 1'b1);
      send_byte(sum_b, 1'b1);
      repeat (TRAILER_LEN) send_byte(8'($urandom_range(0, 255)), 1'b1);
      send_byte(end_byte, 1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (tag_chars_due.size() == 0) begin
            $error("tag beat with nothing pending: tag_char %0h char_index %0d",
                   rsp_tag_char, rsp_char_index);
            fail_count++;
         end else begin
            head_beat = tag_chars_due.pop_front();
            beats_seen++;
            if (rsp_tag_char !== head_beat.tag_char) begin
               $error("tag_char expected %0h actual %0h", head_beat.tag_char, rsp_tag_char);
               fail_count++;
            end
            if (rsp_char_index !== head_beat.char_index) begin
               $error("char_index expected %0d actual %0d",
                      head_beat.char_index, rsp_char_index);
               fail_count++;
            end
            if (rsp_last_char !== head_beat.last_char) begin
               $error("last_char expected %0b actual %0b", head_beat.last_char, rsp_last_char);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("rfid_ascii_frame_checker verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if ($urandom_range(0, 15) == 0) begin
            rsp_burst = ~rsp_burst;
         end
      end
   end

   initial begin
      dir_row_t          directed_rows [DIR_ROWS];
      logic [CHAR_W-1:0] phase_start [N_PHASES];
      logic [CHAR_W-1:0] phase_end [N_PHASES];
      tag_beat_t         beat;
      int                target;
      // Idle extremes, then a good frame whose tag holds the start code,
      // the bytes around the digit range and the field extremes.
      directed_rows = '{
         '{8'h00, ROW_QUIET}, '{8'hFF, ROW_QUIET}, '{8'h02, ROW_QUIET},
         '{8'h02, ROW_QUIET}, '{8'hFF, ROW_QUIET}, '{8'h30, ROW_QUIET},
         '{8'h39, ROW_QUIET}, '{8'h41, ROW_QUIET}, '{8'h46, ROW_QUIET},
         '{8'h00, ROW_QUIET}, '{8'h2F, ROW_QUIET}, '{8'h3A, ROW_QUIET},
         '{8'h37, ROW_QUIET}, '{8'h42, ROW_QUIET}, '{8'h68, ROW_QUIET},
         '{8'h0D, ROW_QUIET}, '{8'h0A, ROW_QUIET}, '{8'h03, ROW_RELEASE}
      };
      phase_start = '{8'h02, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h7E};
      phase_end   = '{8'h03, 8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h7E};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_byte(directed_rows[i].rx, 1'b0);
         if (directed_rows[i].kind == ROW_RELEASE) begin
            for (int k = 0; k < TAG_LEN; k++) begin
               beat.tag_char = directed_rows[i - END_POS + 1 + k].rx;
               beat.char_index = INDEX_W'(k);
               beat.last_char = (k == TAG_LEN - 1);
               tag_chars_due.push_back(beat);
            end
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain_and_settle();
         write_codes(phase_start[ph], phase_end[ph]);
         if (ph == HOLD_PHASE) begin
            hold_rsp = 1'b1;
         end
         target = busy_items + RAND_ITEMS / N_PHASES;
         while (busy_items < target) begin
            send_frame();
         end
         if (ph == SPLIT_PHASE - 1) begin
            // Leave a frame half received so the next code change lands inside it.
            send_byte(start_code_now, 1'b1);
            repeat (7) send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      drain_and_settle();

      $display("Sent %0d bytes (%0d inside frames) under %0d code settings plus reset codes.",
               bytes_sent, busy_items, N_PHASES);
      $display("Frames passed %0d, dropped %0d; %0d tag beats checked.",
               good_frames, dropped_frames, beats_seen);
      if (fail_count == 0) begin
         $display("rfid_ascii_frame_checker verification clean");
      end else begin
         $display("rfid_ascii_frame_checker verification failed");
      end
      $finish;
   end

endmodule
